[hw/rtl/r64d_pkg.sv]
// Shared types, constants and the digit lookup for the radix-64 text value decoder.
`default_nettype none

package r64d_pkg;

   localparam int unsigned CHAR_BITS   = 8;
   localparam int unsigned DIGIT_BITS  = 6;
   localparam int unsigned ACC_BITS    = 30;
   localparam int unsigned IDX_BITS    = 3;
   localparam int unsigned COL_BITS    = 7;
   localparam int unsigned WCOUNT_BITS = 24;
   localparam int unsigned VBITS_BITS  = 5;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam int unsigned RESULT_BITS = 64;
   localparam int unsigned MAX_DIGITS  = 5;

   localparam logic [CHAR_BITS-1:0] NEWLINE_CHAR = 8'd10;

   localparam logic [WCOUNT_BITS-1:0] WORD_COUNT_RST = 24'd1;
   localparam logic [VBITS_BITS-1:0]  VALUE_BITS_RST = 5'd6;
   localparam logic [31:0]            MULT_RST       = 32'd1;

   typedef enum logic [2:0] {
      CSR_WORD_COUNT = 3'd0,
      CSR_VALUE_BITS = 3'd1,
      CSR_SCALE_MODE = 3'd2,
      CSR_MULTIPLIER = 3'd3,
      CSR_OFFSET     = 3'd4
   } csr_index_type;

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [ACC_BITS-1:0]   acc_type;

   // Alphabet 0-9 A-Z a-z { | maps to 0..63, anything else to 0.
   function automatic digit_type digit_of(input logic [CHAR_BITS-1:0] c);
      digit_type d;
      d = '0;
      case (c) inside
         [8'h30:8'h39]: d = DIGIT_BITS'(c - 8'h30);
         [8'h41:8'h5A]: d = DIGIT_BITS'(c - 8'h41 + 8'd10);
         [8'h61:8'h7A]: d = DIGIT_BITS'(c - 8'h61 + 8'd36);
         8'h7B:         d = 6'd62;
         8'h7C:         d = 6'd63;
         default:       d = '0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/radix64_text_value_decoder.sv]
// Radix-64 text value decoder: character parser, multiplier stage and result register.
// Path: a character that completes a value loads the stage 1 register at its transfer,
//   then the product register (31x32 multiply alone), then the result register.
// Throughput: one character per cycle unless rsp_tready stalls the pipeline.
// Reset: synchronous, active high; clears line/digit/count state, pipeline valids, and
//   loads the register defaults (word_count 1, value_bits 6, integer mode, multiplier 1).
`default_nettype none

module radix64_text_value_decoder
   import r64d_pkg::*;
#(
   parameter int unsigned DATA_COLUMNS = 78,
   parameter int unsigned COUNT_BITS   = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // character stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] text_char
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,   // [63:0] value
   output logic              rsp_tlast,   // last_value
   // register writes
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   // Column limits for each digit count, worked out at elaboration.
   localparam logic [COL_BITS-1:0] LIMIT_D1 = COL_BITS'((DATA_COLUMNS / 1) * 1);
   localparam logic [COL_BITS-1:0] LIMIT_D2 = COL_BITS'((DATA_COLUMNS / 2) * 2);
   localparam logic [COL_BITS-1:0] LIMIT_D3 = COL_BITS'((DATA_COLUMNS / 3) * 3);
   localparam logic [COL_BITS-1:0] LIMIT_D4 = COL_BITS'((DATA_COLUMNS / 4) * 4);
   localparam logic [COL_BITS-1:0] LIMIT_D5 = COL_BITS'((DATA_COLUMNS / 5) * 5);

   // ---------------- configuration registers ----------------
   logic [WCOUNT_BITS-1:0] word_count_ff;
   logic [VBITS_BITS-1:0]  value_bits_ff;
   logic                   scale_mode_ff;   // names the result format only
   logic [31:0]            multiplier_ff;
   logic [31:0]            offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= WORD_COUNT_RST;
         value_bits_ff <= VALUE_BITS_RST;
         scale_mode_ff <= 1'b0;
         multiplier_ff <= MULT_RST;
         offset_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_WORD_COUNT: word_count_ff <= csr_data[WCOUNT_BITS-1:0];
            CSR_VALUE_BITS: value_bits_ff <= csr_data[VBITS_BITS-1:0];
            CSR_SCALE_MODE: scale_mode_ff <= csr_data[0];
            CSR_MULTIPLIER: multiplier_ff <= csr_data;
            CSR_OFFSET:     offset_ff     <= csr_data;
            default:        ;   // unused indexes are dropped
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   // Each stage moves when the one after it is empty or moving.
   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic adv_out, adv_s2, adv_s1, accept;

   assign adv_out    = !out_valid_ff || rsp_tready;
   assign adv_s2     = !s2_valid_ff  || adv_out;
   assign adv_s1     = !s1_valid_ff  || adv_s2;
   assign req_tready = adv_s1;
   assign accept     = req_tvalid && req_tready;

   // ---------------- digit count and line limit ----------------
   logic [IDX_BITS-1:0] digits;
   logic [COL_BITS-1:0] limit;

   // value_bits 0 acts as 1 and 31 as 30, so both fold into the end groups.
   always_comb begin
      case (value_bits_ff) inside
         [5'd0:5'd6]:   begin digits = 3'd1; limit = LIMIT_D1; end
         [5'd7:5'd12]:  begin digits = 3'd2; limit = LIMIT_D2; end
         [5'd13:5'd18]: begin digits = 3'd3; limit = LIMIT_D3; end
         [5'd19:5'd24]: begin digits = 3'd4; limit = LIMIT_D4; end
         default:       begin digits = 3'd5; limit = LIMIT_D5; end
      endcase
   end

   // ---------------- character parser state ----------------
   logic [COL_BITS-1:0]   line_column_ff, line_column_in;
   logic [IDX_BITS-1:0]   digit_index_ff, digit_index_in;
   acc_type               digit_acc_ff, digit_acc_in;
   logic [COUNT_BITS-1:0] values_done_ff, values_done_in;
   logic                  draining_ff, draining_in;

   logic                  is_newline;
   acc_type               acc_shift;
   logic [IDX_BITS-1:0]   idx_inc;
   logic [COL_BITS-1:0]   col_inc;
   logic [COUNT_BITS-1:0] done_inc;
   logic [COUNT_BITS-1:0] wc_cmp;
   logic [31:0]           wc_wide;
   logic                  emit, emit_last;

   assign is_newline = (req_tdata == NEWLINE_CHAR);
   assign acc_shift  = {digit_acc_ff[ACC_BITS-DIGIT_BITS-1:0], digit_of(req_tdata)};
   assign idx_inc    = digit_index_ff + 3'd1;
   assign col_inc    = line_column_ff + 7'd1;
   assign done_inc   = values_done_ff + COUNT_BITS'(1);
   assign wc_wide    = {{(32-WCOUNT_BITS){1'b0}}, word_count_ff};
   assign wc_cmp     = wc_wide[COUNT_BITS-1:0];

   always_comb begin
      line_column_in = line_column_ff;
      digit_index_in = digit_index_ff;
      digit_acc_in   = digit_acc_ff;
      values_done_in = values_done_ff;
      draining_in    = draining_ff;
      emit           = 1'b0;
      emit_last      = 1'b0;
      if (accept) begin
         if (draining_ff || is_newline) begin
            // skip to end of line; a newline clears the line state
            if (is_newline) begin
               draining_in    = 1'b0;
               line_column_in = '0;
               digit_index_in = '0;
               digit_acc_in   = '0;
            end
         end else begin
            line_column_in = col_inc;
            if (idx_inc < digits) begin
               digit_index_in = idx_inc;
               digit_acc_in   = acc_shift;
               if (col_inc >= limit) draining_in = 1'b1;
            end else begin
               // value complete
               emit           = 1'b1;
               digit_index_in = '0;
               digit_acc_in   = '0;
               if (done_inc == wc_cmp) begin
                  emit_last      = 1'b1;
                  values_done_in = '0;
                  draining_in    = 1'b1;
               end else begin
                  values_done_in = done_inc;
                  if (col_inc >= limit) draining_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_column_ff <= '0;
         digit_index_ff <= '0;
         digit_acc_ff   <= '0;
         values_done_ff <= '0;
         draining_ff    <= 1'b0;
      end else begin
         line_column_ff <= line_column_in;
         digit_index_ff <= digit_index_in;
         digit_acc_ff   <= digit_acc_in;
         values_done_ff <= values_done_in;
         draining_ff    <= draining_in;
      end
   end

   // ---------------- stage 1: finished value ----------------
   acc_type s1_acc_ff;
   logic    s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv_s1) s1_valid_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         s1_acc_ff  <= acc_shift;
         s1_last_ff <= emit_last;
      end
   end

   // ---------------- stage 2: product ----------------
   // Unsigned 30-bit value times signed 32-bit factor; the integer value makes the
   // product exact in both modes (Q16.16 factor gives a Q16.16 product).
   logic signed [62:0] product;
   logic signed [63:0] s2_prod_ff;
   logic               s2_last_ff;

   assign product = $signed({1'b0, s1_acc_ff}) * $signed(multiplier_ff);

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv_s2) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_s2) begin
         s2_prod_ff <= 64'(product);
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------- stage 3: subtract offset, result register ----------------
   logic signed [63:0] out_value_ff;
   logic               out_last_ff;
   logic signed [63:0] offset_ext;

   assign offset_ext = 64'($signed(offset_ff));

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv_out) out_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_value_ff <= s2_prod_ff - offset_ext;
         out_last_ff  <= s2_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
   // A value always completes at no more than five digits.
   a_digit_index_range: assert property (@(posedge clock) disable iff (reset)
      digit_index_ff < 3'(MAX_DIGITS))
      else $error("digit index beyond five digits");

   // Line column never runs past the data columns.
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      line_column_ff <= COL_BITS'(DATA_COLUMNS))
      else $error("line column past data columns");

   // A newline transfer always leaves a clean line.
   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && is_newline) |=> (line_column_ff == '0 && digit_index_ff == '0
                                  && !draining_ff))
      else $error("newline did not clear line state");

   // The last value of a block puts the parser into draining.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (emit_last) |=> draining_ff && values_done_ff == '0)
      else $error("last value did not start draining");

endmodule

`default_nettype wire
